@@ rtl/touch_sample_qualifier_defines.svh @@
// Assertion macros shared by the touch sample qualifier checkers.
`ifndef TOUCH_SAMPLE_QUALIFIER_DEFINES_SVH
`define TOUCH_SAMPLE_QUALIFIER_DEFINES_SVH

// Clocked assertion, muted while reset is asserted.
`define TSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TSQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/tsq_pkg.sv @@
// Shared types and constants of the touch sample qualifier.
package tsq_pkg;

  localparam int unsigned SampleBitsDef = 10;
  localparam int unsigned FieldW        = 10;
  localparam int unsigned LimitW        = 10;
  localparam int unsigned OpW           = 2;
  localparam int unsigned ActW          = 2;
  localparam logic [LimitW-1:0] LimitReset = 10'd10;

  typedef enum logic [OpW-1:0] {
    OP_PEN_EDGE = 2'd0,
    OP_CONVERT  = 2'd1,
    OP_TICK     = 2'd2
  } op_e;

  typedef enum logic [ActW-1:0] {
    ACT_WAIT_DOWN = 2'd0,
    ACT_MEASURE   = 2'd1,
    ACT_WAIT_UP   = 2'd2,
    ACT_NONE      = 2'd3
  } act_e;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic              pen_up;
    logic [FieldW-1:0] x_sample;
    logic [FieldW-1:0] y_sample;
  } event_t;

  typedef struct packed {
    logic              report_valid;
    logic              touch_pressed;
    logic [FieldW-1:0] x_position;
    logic [FieldW-1:0] y_position;
    act_e              next_action;
  } result_t;

endpackage

@@ rtl/tsq_if.sv @@
// Channel interfaces of the touch sample qualifier: event, result and config.
interface tsq_event_if import tsq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    opcode;
  logic              pen_up;
  logic [FieldW-1:0] x_sample;
  logic [FieldW-1:0] y_sample;

  modport source (output valid, opcode, pen_up, x_sample, y_sample, input ready);
  modport sink   (input valid, opcode, pen_up, x_sample, y_sample, output ready);
endinterface

interface tsq_result_if import tsq_pkg::*;;
  logic              valid;
  logic              ready;
  logic              report_valid;
  logic              touch_pressed;
  logic [FieldW-1:0] x_position;
  logic [FieldW-1:0] y_position;
  logic [ActW-1:0]   next_action;

  modport source (output valid, report_valid, touch_pressed, x_position, y_position,
                  next_action, input ready);
  modport sink   (input valid, report_valid, touch_pressed, x_position, y_position,
                  next_action, output ready);
endinterface

interface tsq_cfg_if import tsq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [LimitW-1:0] error_limit;

  modport source (output valid, error_limit, input ready);
  modport sink   (input valid, error_limit, output ready);
endinterface

@@ rtl/tsq_in_stage.sv @@
// Input register: holds one accepted event word until the engine consumes it.
module tsq_in_stage import tsq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  event_t in_word_i,
  input  logic   advance_i,
  output logic   valid_o,
  output event_t word_o
);

  logic   valid_q;
  event_t word_q;

  // the stage refills whenever its word moves on in the same cycle
  assign in_ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= in_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

@@ rtl/tsq_engine.sv @@
// Qualification engine: sample count, sample stores, limit check and averaging.
module tsq_engine import tsq_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  event_t            event_i,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_limit_i,
  output result_t           result_o
);

  localparam int unsigned CmpW = (SAMPLE_BITS > LimitW) ? SAMPLE_BITS : LimitW;
  localparam int unsigned SumW = SAMPLE_BITS + 2;

  typedef logic [SAMPLE_BITS-1:0] smp_t;

  logic [LimitW-1:0] limit_q;
  logic [1:0]        count_q, count_d;
  smp_t              x_q [3];
  smp_t              y_q [3];
  smp_t              xs, ys;
  logic              store_we;
  logic              checks_ok;
  op_e               op;
  result_t           res;

  function automatic logic near_mean(smp_t a, smp_t b, smp_t c, logic [LimitW-1:0] lim);
    logic [SAMPLE_BITS:0] sum;
    smp_t                 mean;
    smp_t                 delta;
    sum   = {1'b0, a} + {1'b0, b};
    mean  = sum[SAMPLE_BITS:1];
    delta = (c > mean) ? (c - mean) : (mean - c);
    return CmpW'(delta) <= CmpW'(lim);
  endfunction

  function automatic logic [FieldW-1:0] avg4(smp_t a, smp_t b, smp_t c, smp_t d);
    logic [SumW-1:0] s;
    s = SumW'(a) + SumW'(b) + SumW'(c) + SumW'(d);
    return FieldW'(s >> 2);
  endfunction

  assign xs = SAMPLE_BITS'(event_i.x_sample);
  assign ys = SAMPLE_BITS'(event_i.y_sample);
  assign op = op_e'(event_i.opcode);

  // third sample against mean of first two, fourth (incoming) against second and third
  assign checks_ok = near_mean(x_q[0], x_q[1], x_q[2], limit_q) &&
                     near_mean(y_q[0], y_q[1], y_q[2], limit_q) &&
                     near_mean(x_q[1], x_q[2], xs, limit_q) &&
                     near_mean(y_q[1], y_q[2], ys, limit_q);

  always_comb begin
    res               = '0;
    res.next_action   = ACT_NONE;
    count_d           = count_q;
    store_we          = 1'b0;
    case (op)
      OP_PEN_EDGE: begin
        if (event_i.pen_up) begin
          res.report_valid = 1'b1;
          res.next_action  = ACT_WAIT_DOWN;
        end else begin
          res.next_action  = ACT_MEASURE;
        end
      end
      OP_CONVERT: begin
        if (event_i.pen_up) begin
          count_d          = '0;
          res.report_valid = 1'b1;
          res.next_action  = ACT_WAIT_DOWN;
        end else if (count_q == 2'd3) begin
          count_d = '0;
          if (checks_ok) begin
            res.report_valid  = 1'b1;
            res.touch_pressed = 1'b1;
            res.x_position    = avg4(x_q[0], x_q[1], x_q[2], xs);
            res.y_position    = avg4(y_q[0], y_q[1], y_q[2], ys);
            res.next_action   = ACT_WAIT_UP;
          end
        end else begin
          count_d         = count_q + 2'd1;
          store_we        = 1'b1;
          res.next_action = ACT_MEASURE;
        end
      end
      OP_TICK: begin
        res.next_action = event_i.pen_up ? ACT_WAIT_DOWN : ACT_MEASURE;
      end
      default: begin
        // unused opcode: no report, state kept
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      limit_q <= LimitReset;
    end else begin
      if (fire_i) begin
        count_q <= count_d;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_limit_i;
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_store
    always_ff @(posedge clk_i) begin
      if (fire_i && store_we && count_q == 2'(i)) begin
        x_q[i] <= xs;
        y_q[i] <= ys;
      end
    end
  end

  assign result_o = res;

endmodule

@@ rtl/tsq_out_stage.sv @@
// Result register: holds one result word until the downstream side takes it.
module tsq_out_stage import tsq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  result_t in_word_i,
  output logic    advance_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_word_o
);

  logic    valid_q;
  result_t word_q;

  assign advance_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && in_valid_i) begin
      word_q <= in_word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

@@ rtl/touch_sample_qualifier.sv @@
// Touch sample qualifier: takes one event word per cycle and returns one result word
// for each, through the input register and then the result register. The check
// and averaging logic sits between those two registers, so throughput is one word per
// clock as long as the result side takes words; event ready drops only while the
// result register is held. Configuration writes are always accepted and take effect
// at the next clock; write error_limit only while no event is in flight.
module touch_sample_qualifier import tsq_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  tsq_event_if.sink    event_i,
  tsq_cfg_if.sink      cfg_i,
  tsq_result_if.source result_o
);

  event_t  in_word;
  event_t  s1_word;
  logic    s1_valid;
  logic    advance;
  logic    fire;
  result_t eng_res;
  result_t out_word;

  assign in_word = '{opcode:   event_i.opcode,
                     pen_up:   event_i.pen_up,
                     x_sample: event_i.x_sample,
                     y_sample: event_i.y_sample};

  assign fire        = s1_valid && advance;
  assign cfg_i.ready = 1'b1;

  tsq_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (event_i.valid),
    .in_ready_o (event_i.ready),
    .in_word_i  (in_word),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .word_o     (s1_word)
  );

  tsq_engine #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .event_i     (s1_word),
    .cfg_we_i    (cfg_i.valid),
    .cfg_limit_i (cfg_i.error_limit),
    .result_o    (eng_res)
  );

  tsq_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_word_i   (eng_res),
    .advance_o   (advance),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_word_o  (out_word)
  );

  assign result_o.report_valid  = out_word.report_valid;
  assign result_o.touch_pressed = out_word.touch_pressed;
  assign result_o.x_position    = out_word.x_position;
  assign result_o.y_position    = out_word.y_position;
  assign result_o.next_action   = out_word.next_action;

endmodule

@@ rtl/tsq_checker.sv @@
// Port-level checker for the touch sample qualifier, bound to the top level.
`include "touch_sample_qualifier_defines.svh"

module tsq_checker import tsq_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic              report_valid_i,
  input logic              touch_pressed_i,
  input logic [FieldW-1:0] x_position_i,
  input logic [FieldW-1:0] y_position_i,
  input logic [ActW-1:0]   next_action_i
);

  `TSQ_ASSERT(a_hold_stalled, res_valid_i && !res_ready_i |=> res_valid_i && $stable(report_valid_i) && $stable(touch_pressed_i) && $stable(x_position_i) && $stable(y_position_i) && $stable(next_action_i), "result word changed while stalled")
  `TSQ_ASSERT(a_touch_report, res_valid_i && touch_pressed_i |-> report_valid_i && next_action_i == ACT_WAIT_UP, "touch without report or wrong action")
  `TSQ_ASSERT(a_release_word, res_valid_i && report_valid_i && !touch_pressed_i |-> next_action_i == ACT_WAIT_DOWN && x_position_i == '0 && y_position_i == '0, "malformed release")
  `TSQ_ASSERT(a_silent_zero, res_valid_i && !report_valid_i |-> !touch_pressed_i && x_position_i == '0 && y_position_i == '0 && next_action_i != ACT_WAIT_UP, "position without report")
  `TSQ_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !res_valid_i, "result valid during reset")

endmodule

bind touch_sample_qualifier tsq_checker u_tsq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (result_o.valid),
  .res_ready_i     (result_o.ready),
  .report_valid_i  (result_o.report_valid),
  .touch_pressed_i (result_o.touch_pressed),
  .x_position_i    (result_o.x_position),
  .y_position_i    (result_o.y_position),
  .next_action_i   (result_o.next_action)
);

@@ test/tb_top.sv @@
// Testbench for touch_sample_qualifier: event stimulus, result prediction and checking.
`timescale 1ns / 1ps

class touch_tracker;
  logic [tsq_pkg::LimitW-1:0] limit;
  logic [1:0]                 count;
  logic [tsq_pkg::FieldW-1:0] xs [4];
  logic [tsq_pkg::FieldW-1:0] ys [4];
  tsq_pkg::result_t           pending_reports [$];
  int unsigned mismatches, checked, touches, releases, rejects;

  function new();
    limit = tsq_pkg::LimitReset;
    count = '0;
    foreach (xs[i]) begin
      xs[i] = '0;
      ys[i] = '0;
    end
    mismatches = 0;
    checked    = 0;
    touches    = 0;
    releases   = 0;
    rejects    = 0;
  endfunction

  // c must lie within limit of the floor mean of a and b
  function bit near_mean(logic [tsq_pkg::FieldW-1:0] a, logic [tsq_pkg::FieldW-1:0] b,
                         logic [tsq_pkg::FieldW-1:0] c);
    int unsigned m, d;
    m = (32'(a) + 32'(b)) >> 1;
    d = (32'(c) > m) ? 32'(c) - m : m - 32'(c);
    return d <= 32'(limit);
  endfunction

  function tsq_pkg::result_t qualify_event(tsq_pkg::event_t ev);
    tsq_pkg::result_t r;
    int unsigned sum_x, sum_y;
    r = '0;
    r.next_action = tsq_pkg::ACT_NONE;
    case (ev.opcode)
      tsq_pkg::OP_PEN_EDGE: begin
        r.report_valid = ev.pen_up;
        r.next_action  = ev.pen_up ? tsq_pkg::ACT_WAIT_DOWN : tsq_pkg::ACT_MEASURE;
      end
      tsq_pkg::OP_CONVERT: begin
        if (ev.pen_up) begin
          count          = '0;
          r.report_valid = 1'b1;
          r.next_action  = tsq_pkg::ACT_WAIT_DOWN;
        end else begin
          xs[count] = ev.x_sample;
          ys[count] = ev.y_sample;
          if (count == 2'd3) begin
            count = '0;
            if (near_mean(xs[0], xs[1], xs[2]) && near_mean(ys[0], ys[1], ys[2]) &&
                near_mean(xs[1], xs[2], xs[3]) && near_mean(ys[1], ys[2], ys[3])) begin
              sum_x = 32'(xs[0]) + 32'(xs[1]) + 32'(xs[2]) + 32'(xs[3]);
              sum_y = 32'(ys[0]) + 32'(ys[1]) + 32'(ys[2]) + 32'(ys[3]);
              r.report_valid  = 1'b1;
              r.touch_pressed = 1'b1;
              r.x_position    = 10'(sum_x >> 2);
              r.y_position    = 10'(sum_y >> 2);
              r.next_action   = tsq_pkg::ACT_WAIT_UP;
            end
          end else begin
            count         = count + 2'd1;
            r.next_action = tsq_pkg::ACT_MEASURE;
          end
        end
      end
      tsq_pkg::OP_TICK: begin
        r.next_action = ev.pen_up ? tsq_pkg::ACT_WAIT_DOWN : tsq_pkg::ACT_MEASURE;
      end
      default: ;  // unused opcode: state kept, no report
    endcase
    return r;
  endfunction

  function void take_event(tsq_pkg::event_t ev);
    tsq_pkg::result_t r;
    r = qualify_event(ev);
    if (r.touch_pressed) touches++;
    else if (r.report_valid) releases++;
    else if (ev.opcode == tsq_pkg::OP_CONVERT && r.next_action == tsq_pkg::ACT_NONE) rejects++;
    pending_reports.push_back(r);
  endfunction

  task flag_mismatch(string what);
    if (mismatches < 100) $display("result %0d: %s", checked, what);
    mismatches++;
  endtask

  task match_report(tsq_pkg::result_t got);
    tsq_pkg::result_t want;
    if (pending_reports.size() == 0) begin
      flag_mismatch("result word with no event waiting");
      return;
    end
    want = pending_reports.pop_front();
    if (got.report_valid !== want.report_valid)
      flag_mismatch($sformatf("report_valid got %b, expected %b",
                              got.report_valid, want.report_valid));
    if (got.touch_pressed !== want.touch_pressed)
      flag_mismatch($sformatf("touch_pressed got %b, expected %b",
                              got.touch_pressed, want.touch_pressed));
    if (got.x_position !== want.x_position)
      flag_mismatch($sformatf("x_position got %0d, expected %0d",
                              got.x_position, want.x_position));
    if (got.y_position !== want.y_position)
      flag_mismatch($sformatf("y_position got %0d, expected %0d",
                              got.y_position, want.y_position));
    if (got.next_action !== want.next_action)
      flag_mismatch($sformatf("next_action got %0d, expected %0d",
                              got.next_action, want.next_action));
    checked++;
  endtask
endclass

module tb_top;
  import tsq_pkg::*;

  localparam logic [OpW-1:0] OpUnused   = 2'd3;
  localparam int unsigned    CycleLimit = 1_000_000;
  localparam int unsigned    PhaseItems = 340;

  logic clk_i;
  logic rst_ni;

  tsq_event_if  ev_if ();
  tsq_cfg_if    cfg_if ();
  tsq_result_if res_if ();

  touch_sample_qualifier DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .event_i (ev_if),
    .cfg_i   (cfg_if),
    .result_o(res_if)
  );

  touch_tracker board = new();

  bit          no_gaps;
  int          cur_limit;
  int unsigned sent_items;
  int unsigned limit_writes;
  int unsigned cycles;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("touch_sample_qualifier: mismatch");
      $finish;
    end
  end

  // monitors: configuration, accepted events, then results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) board.limit = cfg_if.error_limit;
      if (ev_if.valid && ev_if.ready)
        board.take_event({ev_if.opcode, ev_if.pen_up, ev_if.x_sample, ev_if.y_sample});
      if (res_if.valid && res_if.ready)
        board.match_report({res_if.report_valid, res_if.touch_pressed, res_if.x_position,
                            res_if.y_position, act_e'(res_if.next_action)});
    end
  end

  // mostly no gap, some short, a few long
  function int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // result side back-pressure
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      res_if.ready <= 1'b1;
      repeat (1 + pick_gap()) @(posedge clk_i);
      if (!no_gaps && $urandom_range(0, 2) == 0) begin
        res_if.ready <= 1'b0;
        repeat (1 + pick_gap()) @(posedge clk_i);
      end
    end
  end

  task send_event(logic [OpW-1:0] op, logic up, logic [FieldW-1:0] xv, logic [FieldW-1:0] yv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ev_if.valid    <= 1'b1;
    ev_if.opcode   <= op;
    ev_if.pen_up   <= up;
    ev_if.x_sample <= xv;
    ev_if.y_sample <= yv;
    do @(posedge clk_i); while (!ev_if.ready);
    if (op != OpUnused) sent_items++;
  endtask

  // wait for every result, let the pipe drain, then write error_limit
  task set_limit(logic [LimitW-1:0] value);
    ev_if.valid <= 1'b0;
    while (board.pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_if.valid       <= 1'b1;
    cfg_if.error_limit <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_limit = value;
    limit_writes++;
  endtask

  function int pick_base();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 1023 : 0;
    return $urandom_range(0, 1023);
  endfunction

  // spread around the base: exact, inside, just outside, or loose
  function int pick_spread();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return cur_limit / 2;
      2:       return cur_limit + $urandom_range(1, 4);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  function logic [FieldW-1:0] jitter(int base, int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  task send_touch_set();
    int bx, by, ax, ay;
    bx = pick_base();
    by = pick_base();
    ax = pick_spread();
    ay = pick_spread();
    if ($urandom_range(0, 3) == 0) send_event(OP_PEN_EDGE, 1'b0, 10'($urandom), 10'($urandom));
    for (int i = 0; i < 4; i++) begin
      // edges and ticks with the pen down keep the word count
      if (i > 0 && $urandom_range(0, 7) == 0)
        send_event($urandom_range(0, 1) ? OP_TICK : OP_PEN_EDGE, 1'b0,
                   10'($urandom), 10'($urandom));
      send_event(OP_CONVERT, 1'b0, jitter(bx, ax), jitter(by, ay));
    end
    if ($urandom_range(0, 3) == 0)
      send_event($urandom_range(0, 1) ? OP_PEN_EDGE : OP_CONVERT, 1'b1,
                 10'($urandom), 10'($urandom));
  endtask

  task run_random_phase();
    int r;
    int unsigned phase_end;
    phase_end = sent_items + PhaseItems;
    while (sent_items < phase_end) begin
      if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_touch_set();
      end else if (r < 85) begin
        // aborted set: pen lifted part way
        repeat ($urandom_range(1, 3))
          send_event(OP_CONVERT, 1'b0, 10'($urandom), 10'($urandom));
        send_event(OP_CONVERT, 1'b1, 10'($urandom), 10'($urandom));
      end else begin
        repeat ($urandom_range(1, 3))
          send_event(2'($urandom), 1'($urandom), 10'($urandom), 10'($urandom));
        if ($urandom_range(0, 1) == 0)
          send_event(OP_CONVERT, 1'b1, 10'($urandom), 10'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    ev_if.valid        <= 1'b0;
    ev_if.opcode       <= OP_PEN_EDGE;
    ev_if.pen_up       <= 1'b0;
    ev_if.x_sample     <= '0;
    ev_if.y_sample     <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.error_limit <= '0;
    no_gaps      = 1'b0;
    cur_limit    = LimitReset;
    sent_items   = 0;
    limit_writes = 0;
    cycles       = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset limit of 10
    send_event(OP_PEN_EDGE, 1'b1, 10'd0, 10'd0);
    send_event(OP_PEN_EDGE, 1'b0, 10'd1023, 10'd1023);
    send_event(OP_TICK, 1'b1, 10'd0, 10'd1023);
    send_event(OP_TICK, 1'b0, 10'd1023, 10'd0);
    send_event(OpUnused, 1'b1, 10'd1023, 10'd1023);
    send_event(OP_CONVERT, 1'b1, 10'd1023, 10'd1023);
    repeat (4) send_event(OP_CONVERT, 1'b0, 10'd1023, 10'd1023);
    repeat (4) send_event(OP_CONVERT, 1'b0, 10'd0, 10'd0);
    // distances of exactly the limit pass
    send_event(OP_CONVERT, 1'b0, 10'd100, 10'd200);
    send_event(OP_CONVERT, 1'b0, 10'd102, 10'd200);
    send_event(OP_CONVERT, 1'b0, 10'd111, 10'd190);
    send_event(OP_CONVERT, 1'b0, 10'd106, 10'd195);
    // last Y word one past the limit
    send_event(OP_CONVERT, 1'b0, 10'd500, 10'd500);
    send_event(OP_CONVERT, 1'b0, 10'd500, 10'd500);
    send_event(OP_CONVERT, 1'b0, 10'd500, 10'd500);
    send_event(OP_CONVERT, 1'b0, 10'd500, 10'd511);
    send_event(OP_CONVERT, 1'b0, 10'd300, 10'd300);
    send_event(OP_CONVERT, 1'b1, 10'd300, 10'd300);

    run_random_phase();
    set_limit(10'd0);
    run_random_phase();
    set_limit(10'd1023);
    run_random_phase();
    set_limit(10'($urandom_range(1, 40)));
    run_random_phase();
    set_limit(10'($urandom_range(0, 1023)));
    run_random_phase();
    set_limit(10'($urandom_range(5, 20)));
    run_random_phase();

    ev_if.valid <= 1'b0;
    while (board.pending_reports.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d events under %0d error_limit settings:", sent_items,
             limit_writes + 1);
    $display("  %0d touches, %0d releases, %0d rejected sets, %0d result words checked",
             board.touches, board.releases, board.rejects, board.checked);
    if (board.mismatches == 0) begin
      $display("touch_sample_qualifier: match");
    end else begin
      $display("touch_sample_qualifier: mismatch");
    end
    $finish;
  end
endmodule
